// File: hdl/sfcf_pkg.sv
// Shared types and constants for the SPI flash command framer.
// Used by every module under hdl; no dependencies of its own.
`default_nettype none
package sfcf_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int IDX_W       = 3;   // holds 0..MAX_RESULTS
  localparam int ID_BYTES    = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int POLL_W      = 25;

  localparam logic [7:0]        DUMMY_BYTE = 8'hA5;
  localparam logic [7:0]        NO_OPCODE  = 8'hFF;
  localparam logic [POLL_W-1:0] POLL_LIMIT = 25'h100_0000;

  // register reset values
  localparam logic [4:0] RST_PAGE_SHIFT = 5'd8;
  localparam logic [7:0] RST_READ_OP    = 8'h03;
  localparam logic [7:0] RST_ID_OP      = 8'h9F;
  localparam logic [7:0] RST_PROG_OP    = 8'h02;
  localparam logic [7:0] RST_WREN_OP    = 8'h06;
  localparam logic [7:0] RST_ERASE_OP   = 8'hD8;
  localparam logic [7:0] RST_STATUS_OP  = 8'h05;
  localparam logic [3:0] RST_BUSY_SEL   = 4'd8;

  typedef enum logic [2:0] {
    CMD_READ_ID         = 3'd0,
    CMD_READ_BEGIN      = 3'd1,
    CMD_READ_NEXT       = 3'd2,
    CMD_PROGRAM_BEGIN   = 3'd3,
    CMD_PROGRAM_BYTE    = 3'd4,
    CMD_ERASE           = 3'd5,
    CMD_STATUS_REQUEST  = 3'd6,
    CMD_STATUS_RESPONSE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    REG_PAGE_SHIFT  = 3'd0,
    REG_READ_OP     = 3'd1,
    REG_ID_OP       = 3'd2,
    REG_PROG_OP     = 3'd3,
    REG_WREN_OP     = 3'd4,
    REG_ERASE_OP    = 3'd5,
    REG_STATUS_OP   = 3'd6,
    REG_BUSY_SEL    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_READY   = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_TIMEOUT = 2'd2
  } stat_t;

  // One classified command: the full list of results it expands into.
  typedef struct packed {
    logic                              is_status;
    stat_t                             status;
    logic [IDX_W-1:0]                  count;
    logic [MAX_RESULTS-1:0]            rel;
    logic [MAX_RESULTS-1:0][7:0]       bytes;
  } desc_t;

endpackage
`default_nettype wire

// File: hdl/sfcf_front.sv
// Front end: configuration registers, command classification, address
// formation and busy polling. Emits one descriptor per accepted command. Uses sfcf_pkg.
`default_nettype none
module sfcf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               accept,
  input  wire logic [2:0]         cmd,
  input  wire logic [23:0]        page,
  input  wire logic [15:0]        column,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_frame,
  input  wire logic [7:0]         rx_status,
  input  wire logic               wait_mode,
  output sfcf_pkg::desc_t         desc
);

  logic [4:0] page_shift;
  logic [7:0] read_opcode;
  logic [7:0] id_opcode;
  logic [7:0] program_opcode;
  logic [7:0] write_enable_opcode;
  logic [7:0] erase_opcode;
  logic [7:0] status_opcode;
  logic [3:0] busy_select;
  logic [sfcf_pkg::POLL_W-1:0] poll_count;
  logic [sfcf_pkg::POLL_W-1:0] poll_count_next;

  logic [23:0] paddr;
  logic [23:0] raddr;
  logic        wren_on;
  logic        busy;
  sfcf_pkg::cmd_t cmd_q;

  assign cmd_q   = sfcf_pkg::cmd_t'(cmd);
  assign paddr   = page << page_shift;
  assign raddr   = paddr + {8'd0, column};
  assign wren_on = (write_enable_opcode != sfcf_pkg::NO_OPCODE);
  assign busy    = (rx_status[busy_select[2:0]] == busy_select[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift          <= sfcf_pkg::RST_PAGE_SHIFT;
      read_opcode         <= sfcf_pkg::RST_READ_OP;
      id_opcode           <= sfcf_pkg::RST_ID_OP;
      program_opcode      <= sfcf_pkg::RST_PROG_OP;
      write_enable_opcode <= sfcf_pkg::RST_WREN_OP;
      erase_opcode        <= sfcf_pkg::RST_ERASE_OP;
      status_opcode       <= sfcf_pkg::RST_STATUS_OP;
      busy_select         <= sfcf_pkg::RST_BUSY_SEL;
    end else if (cfg_write) begin
      case (sfcf_pkg::reg_idx_t'(cfg_index))
        sfcf_pkg::REG_PAGE_SHIFT: page_shift          <= cfg_data[4:0];
        sfcf_pkg::REG_READ_OP:    read_opcode         <= cfg_data;
        sfcf_pkg::REG_ID_OP:      id_opcode           <= cfg_data;
        sfcf_pkg::REG_PROG_OP:    program_opcode      <= cfg_data;
        sfcf_pkg::REG_WREN_OP:    write_enable_opcode <= cfg_data;
        sfcf_pkg::REG_ERASE_OP:   erase_opcode        <= cfg_data;
        sfcf_pkg::REG_STATUS_OP:  status_opcode       <= cfg_data;
        sfcf_pkg::REG_BUSY_SEL:   busy_select         <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_count <= '0;
    end else if (accept) begin
      poll_count <= poll_count_next;
    end
  end

  always_comb begin
    desc            = '0;
    desc.status     = sfcf_pkg::STAT_READY;
    poll_count_next = poll_count;
    case (cmd_q)
      sfcf_pkg::CMD_READ_ID: begin
        desc.bytes[0] = id_opcode;
        for (int i = 1; i < sfcf_pkg::MAX_RESULTS; i++) begin
          desc.bytes[i] = sfcf_pkg::DUMMY_BYTE;
        end
        desc.rel[sfcf_pkg::ID_BYTES] = 1'b1;
        desc.count = sfcf_pkg::IDX_W'(sfcf_pkg::ID_BYTES + 1);
      end
      sfcf_pkg::CMD_READ_BEGIN: begin
        desc.bytes = {sfcf_pkg::DUMMY_BYTE, raddr[7:0], raddr[15:8], raddr[23:16],
                      read_opcode};
        desc.count = sfcf_pkg::IDX_W'(5);
      end
      sfcf_pkg::CMD_READ_NEXT: begin
        desc.bytes[0] = sfcf_pkg::DUMMY_BYTE;
        desc.rel[0]   = end_frame;
        desc.count    = sfcf_pkg::IDX_W'(1);
      end
      sfcf_pkg::CMD_PROGRAM_BEGIN: begin
        if (wren_on) begin
          desc.bytes = {paddr[7:0], paddr[15:8], paddr[23:16], program_opcode,
                        write_enable_opcode};
          desc.rel   = 5'b00001;
          desc.count = sfcf_pkg::IDX_W'(5);
        end else begin
          desc.bytes = {8'h00, paddr[7:0], paddr[15:8], paddr[23:16], program_opcode};
          desc.count = sfcf_pkg::IDX_W'(4);
        end
      end
      sfcf_pkg::CMD_PROGRAM_BYTE: begin
        desc.bytes[0] = data_byte;
        desc.rel[0]   = end_frame;
        desc.count    = sfcf_pkg::IDX_W'(1);
      end
      sfcf_pkg::CMD_ERASE: begin
        poll_count_next = '0;
        if (wren_on) begin
          desc.bytes = {paddr[7:0], paddr[15:8], paddr[23:16], erase_opcode,
                        write_enable_opcode};
          desc.rel   = 5'b10001;
          desc.count = sfcf_pkg::IDX_W'(5);
        end else begin
          desc.bytes = {8'h00, paddr[7:0], paddr[15:8], paddr[23:16], erase_opcode};
          desc.rel   = 5'b01000;
          desc.count = sfcf_pkg::IDX_W'(4);
        end
      end
      sfcf_pkg::CMD_STATUS_REQUEST: begin
        desc.bytes[0] = status_opcode;
        desc.bytes[1] = sfcf_pkg::DUMMY_BYTE;
        desc.rel[1]   = 1'b1;
        desc.count    = sfcf_pkg::IDX_W'(2);
      end
      sfcf_pkg::CMD_STATUS_RESPONSE: begin
        desc.is_status = 1'b1;
        desc.count     = sfcf_pkg::IDX_W'(1);
        if (!busy) begin
          desc.status = sfcf_pkg::STAT_READY;
          if (wait_mode) poll_count_next = '0;
        end else if (!wait_mode) begin
          desc.status = sfcf_pkg::STAT_BUSY;
        end else if (poll_count >= sfcf_pkg::POLL_LIMIT) begin
          desc.status     = sfcf_pkg::STAT_TIMEOUT;
          poll_count_next = '0;
        end else begin
          desc.status     = sfcf_pkg::STAT_BUSY;
          poll_count_next = poll_count + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/sfcf_queue.sv
// Small descriptor queue between the front end and the byte sequencer.
// Uses sfcf_pkg for the descriptor type and depth.
`default_nettype none
module sfcf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire sfcf_pkg::desc_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output sfcf_pkg::desc_t      rd_data,
  output logic                 empty
);

  sfcf_pkg::desc_t mem [sfcf_pkg::QUEUE_DEPTH];
  logic [sfcf_pkg::QPTR_W-1:0] wr_ptr;
  logic [sfcf_pkg::QPTR_W-1:0] rd_ptr;
  logic [sfcf_pkg::QPTR_W:0]   fill;

  assign full    = (fill == (sfcf_pkg::QPTR_W+1)'(sfcf_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/sfcf_back.sv
// Back end: walks each queued descriptor one result at a time into the
// output register. Uses sfcf_pkg.
`default_nettype none
module sfcf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sfcf_pkg::desc_t head,
  input  wire logic            head_valid,
  output logic                 head_done,
  output logic                 empty,
  input  wire logic            pop,
  output logic                 byte_valid,
  output logic [7:0]           tx_byte,
  output logic                 release_select,
  output logic                 status_valid,
  output logic [1:0]           device_state,
  output logic                 last
);

  logic                       out_valid;
  logic [sfcf_pkg::IDX_W-1:0] idx;
  logic                       load;
  logic                       at_end;

  assign empty     = !out_valid;
  assign load      = head_valid && (!out_valid || pop);
  assign at_end    = (idx == head.count - 1'b1);
  assign head_done = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= at_end;
      if (head.is_status) begin
        byte_valid     <= 1'b0;
        tx_byte        <= 8'h00;
        release_select <= 1'b0;
        status_valid   <= 1'b1;
        device_state   <= head.status;
      end else begin
        byte_valid     <= 1'b1;
        tx_byte        <= head.bytes[idx];
        release_select <= head.rel[idx];
        status_valid   <= 1'b0;
        device_state   <= sfcf_pkg::STAT_READY;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/spi_flash_command_framer_core.sv
// Top level of the SPI flash command framer.
// Instantiates sfcf_front, sfcf_queue and sfcf_back; uses sfcf_pkg.
`default_nettype none
// Each accepted command is classified in the cycle it is pushed and turned
// into a descriptor holding every byte it produces; a four-entry queue holds
// descriptors until the sequencer walks them out, one result per cycle while
// pop keeps up. A command yields as many results as its descriptor holds: 1
// for read_next, program_byte and status_response, 2 for status_request, 4
// or 5 for the others. Push is taken every cycle while the queue has room, so
// the sustained rate is set by the output side at one result per clock while
// pop keeps up. A command's first result goes through the queue and then
// the output register. Configuration writes take effect on the next edge and
// should only be made when the block is idle.
module spi_flash_command_framer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  cmd,
  input  wire logic [23:0] page,
  input  wire logic [15:0] column,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_frame,
  input  wire logic [7:0]  rx_status,
  input  wire logic        wait_mode,
  output logic             empty,
  input  wire logic        pop,
  output logic             byte_valid,
  output logic [7:0]       tx_byte,
  output logic             release_select,
  output logic             status_valid,
  output logic [1:0]       device_state,
  output logic             last
);

  logic            accept;
  sfcf_pkg::desc_t new_desc;
  sfcf_pkg::desc_t head;
  logic            q_empty;
  logic            head_done;

  assign accept = push && !full;

  sfcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .page      (page),
    .column    (column),
    .data_byte (data_byte),
    .end_frame (end_frame),
    .rx_status (rx_status),
    .wait_mode (wait_mode),
    .desc      (new_desc)
  );

  sfcf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (new_desc),
    .full    (full),
    .rd_en   (head_done),
    .rd_data (head),
    .empty   (q_empty)
  );

  sfcf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (!q_empty),
    .head_done      (head_done),
    .empty          (empty),
    .pop            (pop),
    .byte_valid     (byte_valid),
    .tx_byte        (tx_byte),
    .release_select (release_select),
    .status_valid   (status_valid),
    .device_state   (device_state),
    .last           (last)
  );

endmodule
`default_nettype wire
